[rtl/mpjq_pkg.sv]
// ============================================================================
// mpjq_pkg
// Types and codes shared by the min-priority job queue and its cells.
// ============================================================================
package mpjq_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 4;
    localparam int STAT_W = 2;

    // request kinds (s_tuser)
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // result status codes (m_tuser)
    localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } slot_t;

    // broadcast to every cell for one request
    typedef struct packed {
        logic   ins;
        logic   ext;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

[rtl/mpjq_cell.sv]
// ============================================================================
// mpjq_cell
// One slot of the sorted queue: compares the incoming job against its own
// entry and shifts right on insert or left on extract.
// ============================================================================
module mpjq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  mpjq_pkg::cell_ctrl_t ctrl,
    input  mpjq_pkg::slot_t     left_slot,
    input  logic                left_gt,
    input  mpjq_pkg::slot_t     right_slot,
    output mpjq_pkg::slot_t     slot,
    output logic                gt
);
    import mpjq_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;

    // empty slot acts as +infinity; strict compare keeps ties in arrival order
    assign gt   = !valid_reg || (entry_reg.prio > ctrl.new_entry.prio);
    assign slot = '{valid: valid_reg, entry: entry_reg};

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.ext) begin
            valid_next = right_slot.valid;
            entry_next = right_slot.entry;
        end else if (ctrl.ins && gt) begin
            if (left_gt) begin
                valid_next = left_slot.valid;
                entry_next = left_slot.entry;
            end else begin
                valid_next = 1'b1;
                entry_next = ctrl.new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

endmodule

[rtl/min_priority_job_queue_top.sv]
// ============================================================================
// min_priority_job_queue_top
// Bounded priority queue of jobs kept sorted in a row of compare-and-shift
// cells; dequeue returns the lowest priority value, oldest first on ties.
// ============================================================================
//
//  channel | dir | tdata (low bit up)                     | tuser
//  --------+-----+----------------------------------------+-------------------
//  s_      | in  | job_id[15:0], job_priority[23:16]      | req_type
//  m_      | out | out_id[15:0], out_priority[23:16],     | status[1:0]
//          |     | occupancy[27:24], zero pad [31:28]     |
//
//  One request per cycle while the output is not stalled: every cell compares
//  and shifts in the same cycle, so the result beat is registered in the cycle after the request beat.
//  A new request is taken while the held result is being taken (s_tready =
//  !m_tvalid || m_tready); only a stalled output holds off the input.
//  aresetn (synchronous) empties the queue; no clearing pass is needed.
//
module min_priority_job_queue_top #(
    parameter int DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // job_id[15:0], job_priority[23:16]
    input  logic [0:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_id[15:0], out_priority[23:16], occupancy[27:24]
    output logic [1:0]  m_tuser    // status
);
    import mpjq_pkg::*;

    localparam int CNT_W = ($clog2(DEPTH + 1) > OCC_W) ? $clog2(DEPTH + 1) : OCC_W;

    slot_t      slots [DEPTH];
    logic       gts   [DEPTH];
    cell_ctrl_t ctrl;

    logic             accept;
    logic             is_full, is_empty;
    logic [CNT_W-1:0] count_reg, count_next;

    logic              m_valid_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    entry_t            out_reg, out_next;
    logic [OCC_W-1:0]  occ_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign ctrl.new_entry = entry_t'(s_tdata);
    assign ctrl.ins = accept && (s_tuser[0] == REQ_ENQ) && !is_full;
    assign ctrl.ext = accept && (s_tuser[0] == REQ_DEQ) && !is_empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            slot_t lslot, rslot;
            logic  lgt;
            if (g == 0) begin : g_head
                assign lslot = '0;
                assign lgt   = 1'b0;
            end else begin : g_mid
                assign lslot = slots[g-1];
                assign lgt   = gts[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign rslot = '0;
            end else begin : g_body
                assign rslot = slots[g+1];
            end
            mpjq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .left_slot  (lslot),
                .left_gt    (lgt),
                .right_slot (rslot),
                .slot       (slots[g]),
                .gt         (gts[g])
            );
        end
    endgenerate

    always_comb begin
        count_next  = count_reg;
        status_next = ST_ENQUEUED;
        out_next    = '0;
        if (s_tuser[0] == REQ_ENQ) begin
            if (is_full) begin
                status_next = ST_FULL;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                status_next = ST_EMPTY;
            end else begin
                status_next = ST_DEQUEUED;
                out_next    = slots[0].entry;   // head holds the minimum
                count_next  = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            status_reg <= status_next;
            out_reg    <= out_next;
            occ_reg    <= count_next[OCC_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0000, occ_reg, out_reg.prio, out_reg.id};

endmodule
